// ----- hw/rtl/loc_pkg.sv -----
// Shared types and codes for the lock order checker.
`default_nettype none

package loc_pkg;

  localparam int CMD_W    = 2;
  localparam int THREAD_W = 3;
  localparam int LOCK_W   = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DOUBLE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef logic [3:0] loc_op_t;

  localparam loc_op_t OP_NONE    = 4'd0;
  localparam loc_op_t OP_CAPTURE = 4'd1;
  localparam loc_op_t OP_LOAD    = 4'd2;
  localparam loc_op_t OP_CHK     = 4'd3;
  localparam loc_op_t OP_FRD     = 4'd4;
  localparam loc_op_t OP_FCMP    = 4'd5;
  localparam loc_op_t OP_DEC     = 4'd6;
  localparam loc_op_t OP_WRD     = 4'd7;
  localparam loc_op_t OP_WMAT    = 4'd8;
  localparam loc_op_t OP_WCHK    = 4'd9;
  localparam loc_op_t OP_WEND    = 4'd10;
  localparam loc_op_t OP_SRD     = 4'd11;
  localparam loc_op_t OP_SWR     = 4'd12;
  localparam loc_op_t OP_EMIT    = 4'd13;

  typedef struct packed {
    logic in_range;
    logic idx_zero;
    logic hit;
    logic found;
    logic is_acq;
    logic is_rel;
    logic walk_done;
    logic ordered;
    logic reverse;
    logic shift_done;
    logic out_free;
  } loc_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/loc_if.sv -----
// Event and result channel interfaces of the lock order checker.
`default_nettype none

interface loc_evt_if;
  logic                         valid;
  logic                         ready;
  logic [loc_pkg::CMD_W-1:0]    command;
  logic [loc_pkg::THREAD_W-1:0] thread_index;
  logic [loc_pkg::LOCK_W-1:0]   lock_index;

  modport source (output valid, output command, output thread_index, output lock_index,
                  input ready);
  modport sink (input valid, input command, input thread_index, input lock_index,
                output ready);
endinterface

interface loc_res_if;
  logic                         valid;
  logic                         ready;
  logic [loc_pkg::STATUS_W-1:0] status;
  logic                         lock_held;
  logic                         order_consistent;

  modport source (output valid, output status, output lock_held, output order_consistent,
                  input ready);
  modport sink (input valid, input status, input lock_held, input order_consistent,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/loc_ctrl.sv -----
// Sequencing state machine of the lock order checker.
`default_nettype none

module loc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire loc_pkg::loc_sts_t sts,
  output loc_pkg::loc_op_t      op
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_FRD  = 4'd3;
  localparam logic [3:0] S_FCMP = 4'd4;
  localparam logic [3:0] S_DEC  = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WMAT = 4'd7;
  localparam logic [3:0] S_WCHK = 4'd8;
  localparam logic [3:0] S_WEND = 4'd9;
  localparam logic [3:0] S_SRD  = 4'd10;
  localparam logic [3:0] S_SWR  = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = loc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = loc_pkg::OP_CAPTURE;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        op        = loc_pkg::OP_LOAD;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        op        = loc_pkg::OP_CHK;
        state_nxt = sts.in_range ? S_FRD : S_EMIT;
      end
      S_FRD: begin
        op        = loc_pkg::OP_FRD;
        state_nxt = sts.idx_zero ? S_DEC : S_FCMP;
      end
      S_FCMP: begin
        op        = loc_pkg::OP_FCMP;
        state_nxt = sts.hit ? S_DEC : S_FRD;
      end
      S_DEC: begin
        op = loc_pkg::OP_DEC;
        if (sts.is_acq && !sts.found) begin
          state_nxt = S_WRD;
        end else if (sts.is_rel && sts.found) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WRD: begin
        op        = loc_pkg::OP_WRD;
        state_nxt = sts.walk_done ? S_WEND : S_WMAT;
      end
      S_WMAT: begin
        op        = loc_pkg::OP_WMAT;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        op        = loc_pkg::OP_WCHK;
        state_nxt = (!sts.ordered && sts.reverse) ? S_EMIT : S_WRD;
      end
      S_WEND: begin
        op        = loc_pkg::OP_WEND;
        state_nxt = S_EMIT;
      end
      S_SRD: begin
        op        = loc_pkg::OP_SRD;
        state_nxt = sts.shift_done ? S_EMIT : S_SWR;
      end
      S_SWR: begin
        op        = loc_pkg::OP_SWR;
        state_nxt = S_SRD;
      end
      S_EMIT: begin
        op = loc_pkg::OP_EMIT;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/loc_dp.sv -----
// Datapath of the lock order checker: held stacks, counts, order matrix, result word.
`default_nettype none

module loc_dp #(
  parameter int LOCK_COUNT   = 32,
  parameter int THREAD_COUNT = 8,
  parameter int STACK_DEPTH  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire loc_pkg::loc_op_t              op,
  input  wire logic [loc_pkg::CMD_W-1:0]     in_command,
  input  wire logic [loc_pkg::THREAD_W-1:0]  in_thread_index,
  input  wire logic [loc_pkg::LOCK_W-1:0]    in_lock_index,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [loc_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_lock_held,
  output logic                               out_order_consistent,
  output loc_pkg::loc_sts_t                  sts
);

  localparam int LW    = $clog2(LOCK_COUNT);
  localparam int MROWS = 2 ** LW;
  localparam int TW    = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int SW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int TDEP  = 2 ** TW;
  localparam int SDEP  = 2 ** (TW + SW);

  logic [loc_pkg::CMD_W-1:0]    cmd_r;
  logic [loc_pkg::THREAD_W-1:0] thr_r;
  logic [loc_pkg::LOCK_W-1:0]   lock_r;
  logic [loc_pkg::LOCK_W-1:0]   h_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                idx_r;
  logic [CW-1:0]                pos_r;
  logic                         found_r;
  logic [loc_pkg::STATUS_W-1:0] status_r;
  logic                         held_r;
  logic                         flag_r;
  logic [MROWS-1:0]             lockrow_r;

  logic [loc_pkg::LOCK_W-1:0]   stk_mem [0:SDEP-1];
  logic [loc_pkg::LOCK_W-1:0]   stk_rd_r;
  logic [CW-1:0]                cnt_mem [0:TDEP-1];
  logic [TDEP-1:0]              cnt_vld_r;
  logic [CW-1:0]                cnt_rd_r;
  logic                         cnt_rv_r;
  logic [MROWS-1:0]             mat_mem [0:MROWS-1];
  logic [MROWS-1:0]             mat_vld_r;
  logic [MROWS-1:0]             row_rd_r;
  logic                         row_rv_r;

  logic                         out_valid_r;
  logic [loc_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_held_r;
  logic                         out_flag_r;

  logic [TW-1:0]                thr_a;
  logic [LW-1:0]                lock_a;
  logic [LW-1:0]                h_a;
  logic [LW-1:0]                mat_ra;
  logic [CW-1:0]                idx_dec;
  logic [CW-1:0]                idx_inc;
  logic [CW:0]                  idx_inc_w;
  logic [SW-1:0]                stk_rslot;
  logic [CW-1:0]                cnt_val;
  logic [MROWS-1:0]             row_val;
  logic [MROWS-1:0]             lock_bit;
  logic                         in_range;
  logic                         ordered;
  logic                         reverse;
  logic                         full;
  logic                         shift_done;
  logic                         out_free;
  logic                         stk_rd_en;

  assign thr_a      = TW'(thr_r);
  assign lock_a     = LW'(lock_r);
  assign h_a        = LW'(h_r);
  assign idx_dec    = idx_r - CW'(1);
  assign idx_inc    = idx_r + CW'(1);
  assign idx_inc_w  = {1'b0, idx_r} + (CW + 1)'(1);
  assign cnt_val    = cnt_rv_r ? cnt_rd_r : '0;
  assign row_val    = row_rv_r ? row_rd_r : '0;
  assign lock_bit   = MROWS'(1) << lock_a;
  assign in_range   = (32'(thr_r) < THREAD_COUNT) && (32'(lock_r) < LOCK_COUNT);
  assign ordered    = row_val[lock_a];
  assign reverse    = lockrow_r[h_a];
  assign full       = (32'(cnt_r) >= STACK_DEPTH);
  assign shift_done = (idx_inc_w >= {1'b0, cnt_r});
  assign out_free   = !out_valid_r || out_ready;
  assign mat_ra     = (op == loc_pkg::OP_WMAT) ? LW'(stk_rd_r) : lock_a;

  always_comb begin
    stk_rd_en = 1'b1;
    stk_rslot = idx_r[SW-1:0];
    case (op)
      loc_pkg::OP_FRD: stk_rslot = idx_dec[SW-1:0];
      loc_pkg::OP_WRD: stk_rslot = idx_r[SW-1:0];
      loc_pkg::OP_SRD: stk_rslot = idx_inc[SW-1:0];
      default:         stk_rd_en = 1'b0;
    endcase
  end

  always_comb begin
    sts.in_range   = in_range;
    sts.idx_zero   = (idx_r == '0);
    sts.hit        = (stk_rd_r == lock_r);
    sts.found      = found_r;
    sts.is_acq     = (cmd_r == loc_pkg::CMD_ACQUIRE);
    sts.is_rel     = (cmd_r == loc_pkg::CMD_RELEASE);
    sts.walk_done  = (idx_r == cnt_r);
    sts.ordered    = ordered;
    sts.reverse    = reverse;
    sts.shift_done = shift_done;
    sts.out_free   = out_free;
  end

  // memories and payload
  always_ff @(posedge clk) begin
    if (stk_rd_en) begin
      stk_rd_r <= stk_mem[{thr_a, stk_rslot}];
    end
    if (op == loc_pkg::OP_LOAD) begin
      cnt_rd_r <= cnt_mem[thr_a];
      cnt_rv_r <= cnt_vld_r[thr_a];
    end
    if (op == loc_pkg::OP_LOAD || op == loc_pkg::OP_WMAT) begin
      row_rd_r <= mat_mem[mat_ra];
      row_rv_r <= mat_vld_r[mat_ra];
    end
    unique case (op)
      loc_pkg::OP_CAPTURE: begin
        cmd_r  <= in_command;
        thr_r  <= in_thread_index;
        lock_r <= in_lock_index;
      end
      loc_pkg::OP_CHK: begin
        cnt_r     <= cnt_val;
        idx_r     <= cnt_val;
        lockrow_r <= row_val;
        found_r   <= 1'b0;
        status_r  <= loc_pkg::ST_OK;
        held_r    <= 1'b0;
      end
      loc_pkg::OP_FRD: begin
        if (idx_r != '0) begin
          idx_r <= idx_dec;
        end
      end
      loc_pkg::OP_FCMP: begin
        if (stk_rd_r == lock_r) begin
          found_r <= 1'b1;
          pos_r   <= idx_r;
        end
      end
      loc_pkg::OP_DEC: begin
        held_r <= found_r;
        if (cmd_r == loc_pkg::CMD_ACQUIRE && found_r) begin
          status_r <= loc_pkg::ST_DOUBLE;
        end
        idx_r <= (cmd_r == loc_pkg::CMD_RELEASE) ? pos_r : '0;
      end
      loc_pkg::OP_WMAT: begin
        h_r <= stk_rd_r;
      end
      loc_pkg::OP_WCHK: begin
        if (ordered) begin
          idx_r <= idx_inc;
        end else if (reverse) begin
          status_r <= loc_pkg::ST_CONFLICT;
        end else begin
          mat_mem[h_a] <= row_val | lock_bit;
          idx_r        <= idx_inc;
        end
      end
      loc_pkg::OP_WEND: begin
        if (full) begin
          status_r <= loc_pkg::ST_FULL;
        end else begin
          stk_mem[{thr_a, cnt_r[SW-1:0]}] <= lock_r;
          cnt_mem[thr_a]                  <= cnt_r + CW'(1);
        end
      end
      loc_pkg::OP_SRD: begin
        if (shift_done) begin
          cnt_mem[thr_a] <= cnt_r - CW'(1);
        end
      end
      loc_pkg::OP_SWR: begin
        stk_mem[{thr_a, idx_r[SW-1:0]}] <= stk_rd_r;
        idx_r                           <= idx_inc;
      end
      loc_pkg::OP_EMIT: begin
        if (out_free) begin
          out_status_r <= status_r;
          out_held_r   <= held_r;
          out_flag_r   <= flag_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      mat_vld_r   <= '0;
      flag_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if ((op == loc_pkg::OP_WEND && !full) || (op == loc_pkg::OP_SRD && shift_done)) begin
        cnt_vld_r[thr_a] <= 1'b1;
      end
      if (op == loc_pkg::OP_WCHK && !ordered) begin
        if (reverse) begin
          flag_r <= 1'b0;
        end else begin
          mat_vld_r[h_a] <= 1'b1;
        end
      end
      if (op == loc_pkg::OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_lock_held        = out_held_r;
  assign out_order_consistent = out_flag_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lock_order_checker.sv -----
// Top level of the lock order checker.
`default_nettype none

// Lock order checker: each event word (command, thread, lock) yields one result word
// (status, lock held before the event, sticky order-consistent flag). One event is
// processed at a time by a sequencer over single-port memories: the held stacks,
// per-thread counts and the lock-by-lock order matrix. Each in-range event first
// searches the thread's held stack from the top; an acquire then walks the stack to
// update the order matrix and pushes the lock unless the stack is full (it stops
// early on a double lock or a conflict), and a release that finds the lock shifts
// any newer entries above it down. The per-entry cost is set by the registered
// reads of the stack memory and then of the order-matrix row. The next event word is
// taken while the previous result word still waits on the output.
module lock_order_checker #(
  parameter int LOCK_COUNT   = 32,
  parameter int THREAD_COUNT = 8,
  parameter int STACK_DEPTH  = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  loc_evt_if.sink    in_evt,
  loc_res_if.source  out_res
);

  loc_pkg::loc_op_t  op;
  loc_pkg::loc_sts_t sts;

  loc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_evt.valid),
    .in_ready (in_evt.ready),
    .sts      (sts),
    .op       (op)
  );

  loc_dp #(
    .LOCK_COUNT   (LOCK_COUNT),
    .THREAD_COUNT (THREAD_COUNT),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op                   (op),
    .in_command           (in_evt.command),
    .in_thread_index      (in_evt.thread_index),
    .in_lock_index        (in_evt.lock_index),
    .out_ready            (out_res.ready),
    .out_valid            (out_res.valid),
    .out_status           (out_res.status),
    .out_lock_held        (out_res.lock_held),
    .out_order_consistent (out_res.order_consistent),
    .sts                  (sts)
  );

endmodule

`default_nettype wire
